### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge, skipped while reset is asserted.
`define RGBW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define RGBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBW_ASSERT(lbl, clk, rstn, prop, msg)
`define RGBW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/rgbw_pkg.sv
package rgbw_pkg;

  localparam int PIX_BITS         = 16;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int NUM_COLORS       = 3;
  localparam int GAIN_BITS        = 16;
  localparam int GAIN_FRAC        = 12;
  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 16'd4096;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_EN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORR_EN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RED_GAIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRN_GAIN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLU_GAIN = 3'd4;

  // Color lane order: red, green, blue.
  localparam int LANE_RED = 0;
  localparam int LANE_GRN = 1;
  localparam int LANE_BLU = 2;

  typedef struct packed {
    logic                 white_en;
    logic                 corr_en;
    logic [GAIN_BITS-1:0] red_gain;
    logic [GAIN_BITS-1:0] grn_gain;
    logic [GAIN_BITS-1:0] blu_gain;
  } cfg_t;

endpackage

### hdl/rgbw_cfg.sv
module rgbw_cfg
  import rgbw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIX_BITS-1:0]     cfg_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_en <= 1'b1;
      cfg_r.corr_en  <= 1'b0;
      cfg_r.red_gain <= UNITY_GAIN;
      cfg_r.grn_gain <= UNITY_GAIN;
      cfg_r.blu_gain <= UNITY_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WHITE_EN: cfg_r.white_en <= cfg_data[0];
        REG_CORR_EN:  cfg_r.corr_en  <= cfg_data[0];
        REG_RED_GAIN: cfg_r.red_gain <= cfg_data[GAIN_BITS-1:0];
        REG_GRN_GAIN: cfg_r.grn_gain <= cfg_data[GAIN_BITS-1:0];
        REG_BLU_GAIN: cfg_r.blu_gain <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/rgbw_white.sv
`include "assert_macros.svh"
module rgbw_white
  import rgbw_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    white_en,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIX_BITS-1:0]     in_red,
  input  logic [PIX_BITS-1:0]     in_green,
  input  logic [PIX_BITS-1:0]     in_blue,
  output logic                    dn_valid,
  input  logic                    dn_stall,
  output logic [CHANNEL_BITS-1:0] dn_diff [NUM_COLORS],
  output logic [CHANNEL_BITS-1:0] dn_white
);

  logic                    valid_r;
  logic [CHANNEL_BITS-1:0] diff_r [NUM_COLORS];
  logic [CHANNEL_BITS-1:0] white_r;

  logic                    ready;
  logic [CHANNEL_BITS-1:0] chan [NUM_COLORS];
  logic [CHANNEL_BITS-1:0] min_rg;
  logic [CHANNEL_BITS-1:0] white_nxt;

  assign ready    = !valid_r || !dn_stall;
  assign in_stall = !ready;

  assign chan[LANE_RED] = in_red[CHANNEL_BITS-1:0];
  assign chan[LANE_GRN] = in_green[CHANNEL_BITS-1:0];
  assign chan[LANE_BLU] = in_blue[CHANNEL_BITS-1:0];

  always_comb begin
    min_rg    = (chan[LANE_GRN] < chan[LANE_RED]) ? chan[LANE_GRN] : chan[LANE_RED];
    white_nxt = '0;
    if (white_en) begin
      white_nxt = (chan[LANE_BLU] < min_rg) ? chan[LANE_BLU] : min_rg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      white_r <= white_nxt;
      for (int i = 0; i < NUM_COLORS; i++) begin
        diff_r[i] <= chan[i] - white_nxt;
      end
    end
  end

  assign dn_valid = valid_r;
  assign dn_diff  = diff_r;
  assign dn_white = white_r;

  // The white level is the smallest channel, so one difference must be zero.
  `RGBW_ASSERT(a_min_lane_zero, clk, rst_n, (valid_r && white_en) |-> (diff_r[LANE_RED] == '0 || diff_r[LANE_GRN] == '0 || diff_r[LANE_BLU] == '0), "no zero lane after white removal")
  // Nothing is held after reset.
  `RGBW_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !valid_r, "stage valid after reset")

endmodule

### hdl/rgbw_gain.sv
`include "assert_macros.svh"
module rgbw_gain
  import rgbw_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    up_valid,
  output logic                    up_stall,
  input  logic [CHANNEL_BITS-1:0] up_diff [NUM_COLORS],
  input  logic [CHANNEL_BITS-1:0] up_white,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIX_BITS-1:0]     out_color [NUM_COLORS],
  output logic [PIX_BITS-1:0]     out_white
);

  localparam int PROD_BITS  = CHANNEL_BITS + GAIN_BITS;
  localparam int SCALE_BITS = PROD_BITS - GAIN_FRAC;

  logic                    valid_r;
  logic [CHANNEL_BITS-1:0] color_r [NUM_COLORS];
  logic [CHANNEL_BITS-1:0] white_r;

  logic                    ready;
  logic [GAIN_BITS-1:0]    gain  [NUM_COLORS];
  logic [PROD_BITS-1:0]    prod  [NUM_COLORS];
  logic [SCALE_BITS-1:0]   scale [NUM_COLORS];
  logic [CHANNEL_BITS-1:0] color_nxt [NUM_COLORS];

  assign ready    = !valid_r || !out_stall;
  assign up_stall = !ready;

  assign gain[LANE_RED] = cfg.corr_en ? cfg.red_gain : UNITY_GAIN;
  assign gain[LANE_GRN] = cfg.corr_en ? cfg.grn_gain : UNITY_GAIN;
  assign gain[LANE_BLU] = cfg.corr_en ? cfg.blu_gain : UNITY_GAIN;

  // Scale each lane, drop the fraction, clamp at full scale.
  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      prod[i]      = PROD_BITS'(up_diff[i]) * PROD_BITS'(gain[i]);
      scale[i]     = prod[i][PROD_BITS-1:GAIN_FRAC];
      color_nxt[i] = (scale[i][SCALE_BITS-1:CHANNEL_BITS] != '0)
                     ? {CHANNEL_BITS{1'b1}} : scale[i][CHANNEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      color_r <= color_nxt;
      white_r <= up_white;
    end
  end

  assign out_valid = valid_r;
  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      out_color[i] = PIX_BITS'(color_r[i]);
    end
  end
  assign out_white = PIX_BITS'(white_r);

  // Unity gain passes the difference through unchanged.
  `RGBW_ASSERT(a_unity_pass, clk, rst_n, (ready && up_valid && !cfg.corr_en) |=> (color_r[LANE_RED] == $past(up_diff[LANE_RED]) && color_r[LANE_BLU] == $past(up_diff[LANE_BLU])), "unity gain changed a lane")
  // A gain of zero clears the lane.
  `RGBW_ASSERT(a_zero_gain, clk, rst_n, (ready && up_valid && cfg.corr_en && cfg.grn_gain == '0) |=> (color_r[LANE_GRN] == '0), "zero gain left a nonzero lane")

endmodule

### hdl/rgb_to_rgbw_with_gain_correction_top.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_red, in_green, in_blue (16 b each)
// out      out_valid / out_stall  out_red, out_green, out_blue, out_white (16 b)
// cfg      cfg_valid / cfg_ready  cfg_index (3 b), cfg_data (16 b)
//
// One pixel a cycle while out_stall stays low; each beat taken passes through
// the white removal stage, then the gain multiply stage, to the output.
// Reset (rst_n low, synchronous) empties both stages and loads the register
// defaults: white on, correction off, all gains 1.0.
// out_stall holds both stages in place; in_stall rises only when both are full.
// cfg_ready is always high; a write to an unused index is dropped.
module rgb_to_rgbw_with_gain_correction_top
  import rgbw_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input pixel channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIX_BITS-1:0]     in_red,
  input  logic [PIX_BITS-1:0]     in_green,
  input  logic [PIX_BITS-1:0]     in_blue,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIX_BITS-1:0]     out_red,
  output logic [PIX_BITS-1:0]     out_green,
  output logic [PIX_BITS-1:0]     out_blue,
  output logic [PIX_BITS-1:0]     out_white,
  // register write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIX_BITS-1:0]     cfg_data
);

  cfg_t                    cfg;
  logic                    mid_valid;
  logic                    mid_stall;
  logic [CHANNEL_BITS-1:0] mid_diff [NUM_COLORS];
  logic [CHANNEL_BITS-1:0] mid_white;
  logic [PIX_BITS-1:0]     color [NUM_COLORS];

  // Register file; user changes values only while pipe is empty; not enforced.
  rgbw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage one: mask to channel width, take the minimum (zero with white off), subtract it.
  rgbw_white #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_white (
    .clk      (clk),
    .rst_n    (rst_n),
    .white_en (cfg.white_en),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .dn_valid (mid_valid),
    .dn_stall (mid_stall),
    .dn_diff  (mid_diff),
    .dn_white (mid_white)
  );

  // Stage two: Q4.12 gain per lane, floor, saturate; drives the output beat.
  rgbw_gain #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (mid_valid),
    .up_stall  (mid_stall),
    .up_diff   (mid_diff),
    .up_white  (mid_white),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_color (color),
    .out_white (out_white)
  );

  assign out_red   = color[LANE_RED];
  assign out_green = color[LANE_GRN];
  assign out_blue  = color[LANE_BLU];

endmodule

### verif/testbench.sv
`default_nettype none

module testbench
  import rgbw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Write indexes past the blue gain select no register; the block drops them.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [PIX_BITS-1:0] CHAN_MAX = 16'hFFFF;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = 16'hFFFF;

  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_PIXELS  = 100;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic [PIX_BITS-1:0] white;
  } rgbw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [PIX_BITS-1:0]     in_red    = '0;
  logic [PIX_BITS-1:0]     in_green  = '0;
  logic [PIX_BITS-1:0]     in_blue   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PIX_BITS-1:0]     out_red;
  logic [PIX_BITS-1:0]     out_green;
  logic [PIX_BITS-1:0]     out_blue;
  logic [PIX_BITS-1:0]     out_white;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PIX_BITS-1:0]     cfg_data  = '0;

  // Shadow of the register file, starting at the reset defaults.
  cfg_t reg_shadow = '{white_en: 1'b1, corr_en: 1'b0, red_gain: UNITY_GAIN,
                       grn_gain: UNITY_GAIN, blu_gain: UNITY_GAIN};

  pixel_t pixel_q[$];          // pixels waiting to be sent
  rgbw_t  rgbw_expected_q[$];  // converted pixels owed by the block, oldest first
  pixel_t next_pix;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_run      = 0;
  // While set, both sides run flat out: no gaps, no stalls.
  bit          quiet          = 1'b0;

  rgb_to_rgbw_with_gain_correction_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_white (out_white),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Scale one color difference by a Q4.12 gain: floor, then clamp at full scale.
  function automatic logic [PIX_BITS-1:0] apply_gain(input logic [PIX_BITS-1:0] diff,
                                                     input logic [GAIN_BITS-1:0] gain);
    logic [31:0] prod;
    prod = (32'(diff) * 32'(gain)) >> GAIN_FRAC;
    return (prod > 32'(CHAN_MAX)) ? CHAN_MAX : prod[PIX_BITS-1:0];
  endfunction

  // Predict one converted pixel under the given register settings.
  function automatic rgbw_t rgbw_convert(input cfg_t regs, input logic [PIX_BITS-1:0] r,
                                         input logic [PIX_BITS-1:0] g,
                                         input logic [PIX_BITS-1:0] b);
    logic [PIX_BITS-1:0]  w;
    logic [GAIN_BITS-1:0] gr;
    logic [GAIN_BITS-1:0] gg;
    logic [GAIN_BITS-1:0] gb;
    rgbw_t                o;
    w = '0;
    if (regs.white_en) begin
      w = r;
      if (g < w) w = g;
      if (b < w) w = b;
    end
    gr = UNITY_GAIN;
    gg = UNITY_GAIN;
    gb = UNITY_GAIN;
    if (regs.corr_en) begin
      gr = regs.red_gain;
      gg = regs.grn_gain;
      gb = regs.blu_gain;
    end
    o.red   = apply_gain(r - w, gr);
    o.green = apply_gain(g - w, gg);
    o.blue  = apply_gain(b - w, gb);
    o.white = w;
    return o;
  endfunction

  // Issue one register write, hold it until taken, then mirror it in the shadow.
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [PIX_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WHITE_EN: reg_shadow.white_en = data[0];
      REG_CORR_EN:  reg_shadow.corr_en  = data[0];
      REG_RED_GAIN: reg_shadow.red_gain = data;
      REG_GRN_GAIN: reg_shadow.grn_gain = data;
      REG_BLU_GAIN: reg_shadow.blu_gain = data;
      default: ;  // spare index: dropped by the block
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [PIX_BITS-1:0] r, input logic [PIX_BITS-1:0] g,
                             input logic [PIX_BITS-1:0] b);
    pixel_q.push_back('{red: r, green: g, blue: b});
  endtask

  // Block until the sender is empty and every converted pixel is back, then
  // let the two pipeline stages settle. Look on the falling edge so the
  // driver's updates from the rising edge are visible.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || rgbw_expected_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return UNITY_GAIN;
      3:       return UNITY_GAIN + GAIN_BITS'($urandom_range(0, 64)) - GAIN_BITS'(32);
      4:       return GAIN_BITS'($urandom_range(4096, 16384));
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_BITS-1:0] pick_extreme();
    return $urandom_range(0, 1) ? CHAN_MAX : '0;
  endfunction

  // Mix plain random pixels with the shapes that matter for white extraction:
  // gray pixels, a zero channel, full-scale corners, and near-gray pixels.
  task automatic queue_random_pixel();
    logic [PIX_BITS-1:0] base;
    base = PIX_BITS'($urandom);
    case ($urandom_range(0, 9))
      0: queue_pixel(base, base, base);
      1: begin
        case ($urandom_range(0, 2))
          0:       queue_pixel('0, PIX_BITS'($urandom), PIX_BITS'($urandom));
          1:       queue_pixel(PIX_BITS'($urandom), '0, PIX_BITS'($urandom));
          default: queue_pixel(PIX_BITS'($urandom), PIX_BITS'($urandom), '0);
        endcase
      end
      2: queue_pixel(pick_extreme(), pick_extreme(), pick_extreme());
      3: queue_pixel(base | PIX_BITS'($urandom_range(0, 15)),
                     base | PIX_BITS'($urandom_range(0, 15)),
                     base | PIX_BITS'($urandom_range(0, 15)));
      default: queue_pixel(PIX_BITS'($urandom), PIX_BITS'($urandom), PIX_BITS'($urandom));
    endcase
  endtask

  // Driver: launch pixels in bursts of random length with random gaps between.
  // Record the expected conversion on the edge where a beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall)
        rgbw_expected_q.push_back(rgbw_convert(reg_shadow, in_red, in_green, in_blue));
      // Hold a stalled beat as it is; otherwise advance to the next one.
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !quiet) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          next_pix = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_red   <= next_pix.red;
          in_green <= next_pix.green;
          in_blue  <= next_pix.blue;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall in alternating runs of random length, and check every
  // beat taken against the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rgbw_expected_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("[%0d] unexpected beat: r=%h g=%h b=%h w=%h", cycle_count,
                     out_red, out_green, out_blue, out_white);
          mismatch_count++;
        end else begin
          if (out_red !== rgbw_expected_q[0].red || out_green !== rgbw_expected_q[0].green ||
              out_blue !== rgbw_expected_q[0].blue ||
              out_white !== rgbw_expected_q[0].white) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("[%0d] beat mismatch: expected r=%h g=%h b=%h w=%h, got r=%h g=%h b=%h w=%h",
                       cycle_count, rgbw_expected_q[0].red, rgbw_expected_q[0].green,
                       rgbw_expected_q[0].blue, rgbw_expected_q[0].white,
                       out_red, out_green, out_blue, out_white);
            mismatch_count++;
          end
          void'(rgbw_expected_q.pop_front());
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
        stall_run <= 0;
      end else if (stall_run != 0) begin
        stall_run <= stall_run - 1;
      end else begin
        // Flip between a flowing run and a stalled run, each of random length.
        out_stall <= !out_stall;
        stall_run <= out_stall ? $urandom_range(0, 12) : $urandom_range(0, 7);
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    // Hold reset from time zero, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: white on, correction off. Cover black, full white,
    // pure primaries and a pixel with distinct channels.
    queue_pixel('0, '0, '0);
    queue_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX);
    queue_pixel(CHAN_MAX, '0, '0);
    queue_pixel('0, CHAN_MAX, '0);
    queue_pixel('0, '0, CHAN_MAX);
    queue_pixel(16'h1234, 16'h8000, CHAN_MAX);
    wait_drained();

    // White off, largest gain on red (saturates), zero gain on green
    // (color cleared), unity on blue.
    cfg_write(REG_WHITE_EN, 16'd0);
    cfg_write(REG_CORR_EN, 16'd1);
    cfg_write(REG_RED_GAIN, GAIN_MAX);
    cfg_write(REG_GRN_GAIN, 16'd0);
    cfg_write(REG_BLU_GAIN, UNITY_GAIN);
    queue_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX);
    queue_pixel(16'd1, 16'd2, 16'd3);
    queue_pixel(CHAN_MAX, 16'h8000, '0);
    queue_pixel('0, '0, '0);
    queue_pixel(16'h0FFF, 16'h1000, 16'h7FFF);
    wait_drained();

    // White back on with half, double and largest gains.
    cfg_write(REG_WHITE_EN, 16'd1);
    cfg_write(REG_RED_GAIN, 16'd2048);
    cfg_write(REG_GRN_GAIN, 16'd8192);
    cfg_write(REG_BLU_GAIN, GAIN_MAX);
    queue_pixel(16'h1000, 16'h3000, 16'h5000);
    queue_pixel(CHAN_MAX, '0, CHAN_MAX);
    queue_pixel(16'd5, 16'd7, 16'd9);
    queue_pixel(16'd0, 16'h8001, CHAN_MAX);
    wait_drained();

    // Writes to spare indexes must change nothing; then drop correction while
    // the odd gains stay loaded.
    cfg_write(REG_SPARE_FIRST, 16'hFFFF);
    cfg_write(REG_SPARE_LAST, 16'h0000);
    queue_pixel(16'h4000, 16'h2000, 16'hF000);
    queue_pixel(16'hAAAA, 16'h5555, 16'hFFFE);
    wait_drained();
    cfg_write(REG_CORR_EN, 16'd0);
    queue_pixel(16'h4000, 16'h2000, 16'hF000);
    queue_pixel(CHAN_MAX, 16'd1, 16'h8000);
    wait_drained();

    // Random phases, each under fresh register settings. The first two pin
    // the extremes: every gain at its largest, then every gain zero.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      cfg_write(REG_WHITE_EN, PIX_BITS'($urandom));
      cfg_write(REG_CORR_EN, (phase < 2) ? 16'd1 : PIX_BITS'($urandom));
      cfg_write(REG_RED_GAIN, (phase == 0) ? GAIN_MAX : (phase == 1) ? '0 : pick_gain());
      cfg_write(REG_GRN_GAIN, (phase == 0) ? GAIN_MAX : (phase == 1) ? '0 : pick_gain());
      cfg_write(REG_BLU_GAIN, (phase == 0) ? GAIN_MAX : (phase == 1) ? '0 : pick_gain());
      if (phase % 2 == 1)
        cfg_write(CFG_IDX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  PIX_BITS'($urandom));
      quiet = (phase % 5 == 2);
      for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
        queue_random_pixel();
        // Pause the sender mid-phase now and then until the pipeline is empty.
        if (phase % 3 == 0 && n == PHASE_PIXELS / 2)
          wait_drained();
      end
      wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && rgbw_expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/rgbw_pkg.sv
hdl/rgbw_cfg.sv
hdl/rgbw_white.sv
hdl/rgbw_gain.sv
hdl/rgb_to_rgbw_with_gain_correction_top.sv
verif/testbench.sv
